// ===== rtl/core/tpw_pkg.sv =====
// Shared constants, types and widths for the tube polynomial waveshaper.
// Used by the serial multiplier, the serial divider and the top level.
// Depends on nothing.
package tpw_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;

    localparam int AMT_W      = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TUBE_AMOUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RATE   = 1'b1;

    localparam logic [AMT_W-1:0] AMOUNT_MAX = 10'd1000;
    localparam int P_STEP   = 200;
    localparam int P_STEPS  = 5;
    localparam int P_W      = 3;

    localparam int GAIN_FRAC   = 30;
    localparam int GAIN_W      = 31;
    localparam int GAIN_INT_K  = 241179;
    localparam int GAIN_REM_K  = 808;
    localparam int ROUND_K     = 500;
    localparam int RECIP_K     = 1073742;
    localparam int RECIP_SHIFT = 30;
    localparam int N_W         = 20;
    localparam int BASE_W      = 28;
    localparam int RECIP_W     = 21;
    localparam int FRAC_Q_W    = 10;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = (SAMPLE_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int MUL_B_W   = MUL_STEPS * DIGIT_W;
    localparam int MUL_A_W   = (GAIN_W > SAMPLE_BITS) ? GAIN_W : SAMPLE_BITS;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    localparam int DIV_W     = SAMPLE_BITS + 2;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [SAMPLE_BITS:0]   ONE_Q   = (SAMPLE_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {FRAC_BITS{1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_NEG = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== rtl/core/tpw_mul.sv =====
// Digit-serial unsigned multiplier, four multiplier bits per cycle, LSB first.
// Depends on tpw_pkg for the operand widths and the status type.
module tpw_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tpw_pkg::MUL_A_W-1:0]   a,
    input  logic [tpw_pkg::MUL_B_W-1:0]   b,
    output tpw_pkg::unit_status_t         status,
    output logic [tpw_pkg::MUL_P_W-1:0]   product
);
    import tpw_pkg::*;

    logic [MUL_A_W-1:0]         a_reg;
    logic [MUL_P_W-1:0]         acc_reg;
    logic [MUL_P_W-1:0]         acc_next;
    logic [MUL_CNT_W-1:0]       cnt_reg;
    logic [MUL_CNT_W-1:0]       cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [DIGIT_W-1:0]         digit;
    logic [MUL_A_W+DIGIT_W-1:0] partial;

    // The upper part of the accumulator takes one partial product per cycle
    // while the multiplier digits shift out of the lower part.
    assign digit   = acc_reg[DIGIT_W-1:0];
    assign partial = (MUL_A_W + DIGIT_W)'(acc_reg[MUL_P_W-1 -: MUL_A_W])
                   + (MUL_A_W + DIGIT_W)'(a_reg) * (MUL_A_W + DIGIT_W)'(digit);

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = {{MUL_A_W{1'b0}}, b};
            cnt_next  = MUL_CNT_W'(MUL_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {partial, acc_reg[MUL_B_W-1:DIGIT_W]};
            cnt_next = cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

// ===== rtl/core/tpw_div.sv =====
// Bit-serial restoring divider for a wide numerator and a small divisor.
// Depends on tpw_pkg for the widths and the status type.
module tpw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpw_pkg::DIV_W-1:0]   numer,
    input  logic [tpw_pkg::P_W-1:0]     denom,
    output tpw_pkg::unit_status_t       status,
    output logic [tpw_pkg::DIV_W-1:0]   quotient
);
    import tpw_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [P_W-1:0]       rem_reg;
    logic [P_W-1:0]       rem_next;
    logic [P_W-1:0]       den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [P_W:0]         trial;
    logic [P_W:0]         diff;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = numer;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[P_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[P_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== rtl/core/tube_polynomial_waveshaper_top.sv =====
// Top level of the tube polynomial waveshaper: registers, gain set-up, sequencer.
// Depends on tpw_pkg, tpw_mul and tpw_div.
// From input transfer to output valid a sample passes the gain product, p power products
// (p = 1..6 from tube_amount), two serial divisions and the output register. One sample is
// in work at a time: a new input is taken only after the last one is loaded for output.
// Reset clears the configuration registers, sequencer state and sample history; input waits
// after reset or a tube_amount write while the gain pipeline settles.
module tube_polynomial_waveshaper_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tpw_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tpw_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic                                 frame_last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tpw_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                                 out_frame_last
);
    import tpw_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_GAIN  = 6'b000010,
        ST_POW   = 6'b000100,
        ST_DIV_T = 6'b001000,
        ST_DIV_S = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;

    logic [AMT_W-1:0]         tube_amount_reg;
    logic                     high_rate_mode_reg;
    logic [SETTLE_W-1:0]      settle_reg;
    logic [SETTLE_W-1:0]      settle_next;

    logic [AMT_W-1:0]         amt_c;
    logic [AMT_W-1:0]         amt_rest;
    logic [P_W-1:0]           p_calc;
    logic [N_W-1:0]           round_num_reg;
    logic [BASE_W-1:0]        base_reg;
    logic [BASE_W-1:0]        base2_reg;
    logic [N_W+RECIP_W-1:0]   recip_prod;
    logic [FRAC_Q_W-1:0]      frac_q_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [P_W-1:0]           p_reg;
    logic [P_W-1:0]           p_plus;

    logic [SAMPLE_BITS-1:0]   prior_input_reg;
    logic [SAMPLE_BITS-1:0]   prior_shaped_reg;
    logic [SAMPLE_BITS:0]     sum_in;
    logic [SAMPLE_BITS-1:0]   x_avg;
    logic [SAMPLE_BITS-1:0]   x_mag;
    logic                     in_xfer;

    logic                     neg_reg;
    logic                     frame_reg;
    logic [SAMPLE_BITS-1:0]   mag_reg;
    logic [P_W-1:0]           pow_cnt_reg;
    logic [P_W-1:0]           pow_cnt_next;
    logic [SAMPLE_BITS-1:0]   sat_reg;

    logic [SAMPLE_BITS:0]     gain_q;
    logic [SAMPLE_BITS:0]     gain_q_adj;
    logic [SAMPLE_BITS-1:0]   mag_clamp;
    logic [SAMPLE_BITS-1:0]   pw;
    logic [SAMPLE_BITS-1:0]   mag_diff;
    logic [DIV_W-1:0]         scaled_diff;
    logic [SAMPLE_BITS-1:0]   s_sat;
    logic [SAMPLE_BITS:0]     sum_out;
    logic [SAMPLE_BITS-1:0]   out_value;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                     out_frame_last_reg;
    logic                     out_free;
    logic                     out_load;
    logic                     mag_load;
    logic                     sat_load;

    logic                     mul_start;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    unit_status_t             mul_status;
    logic [MUL_P_W-1:0]       mul_product;

    logic                     div_start;
    logic [DIV_W-1:0]         div_numer;
    logic [P_W-1:0]           div_denom;
    unit_status_t             div_status;
    logic [DIV_W-1:0]         div_quot;

    tpw_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_status),
        .product (mul_product)
    );

    tpw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .status   (div_status),
        .quotient (div_quot)
    );

    // Configuration registers and the settling count for the gain pipeline.
    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_we && (cfg_index == REG_TUBE_AMOUNT))
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tube_amount_reg    <= '0;
            high_rate_mode_reg <= 1'b0;
            settle_reg         <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TUBE_AMOUNT: tube_amount_reg    <= cfg_data[AMT_W-1:0];
                    REG_HIGH_RATE:   high_rate_mode_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // Gain set-up: the fraction is amount times 241179 plus a rounded
    // (amount * 808 + 500) / 1000, the division done by a reciprocal product.
    always_comb
    begin
        amt_c    = (tube_amount_reg > AMOUNT_MAX) ? AMOUNT_MAX : tube_amount_reg;
        amt_rest = AMOUNT_MAX - amt_c;
        p_calc   = P_W'(1);
        for (int k = 1; k <= P_STEPS; k++)
        begin
            if (amt_rest >= AMT_W'(k * P_STEP))
            begin
                p_calc = p_calc + P_W'(1);
            end
        end
    end

    assign recip_prod = (N_W + RECIP_W)'(round_num_reg) * (N_W + RECIP_W)'(RECIP_K);

    always_ff @(posedge clk)
    begin
        round_num_reg <= N_W'(amt_c) * N_W'(GAIN_REM_K) + N_W'(ROUND_K);
        base_reg      <= BASE_W'(amt_c) * BASE_W'(GAIN_INT_K);
        p_reg         <= p_calc;
        base2_reg     <= base_reg;
        frac_q_reg    <= recip_prod[RECIP_SHIFT +: FRAC_Q_W];
        gain_reg      <= GAIN_ONE + GAIN_W'(base2_reg) + GAIN_W'(frac_q_reg);
    end

    assign p_plus = p_reg + P_W'(1);

    // Input side: optional averaging with the previous input, then magnitude.
    assign in_stall = (state_reg != ST_IDLE) || (settle_reg != '0);
    assign in_xfer  = in_valid && !in_stall;
    assign sum_in   = {in_sample[SAMPLE_BITS-1], in_sample}
                    + {prior_input_reg[SAMPLE_BITS-1], prior_input_reg};
    assign x_avg    = high_rate_mode_reg ? sum_in[SAMPLE_BITS:1] : in_sample;
    assign x_mag    = x_avg[SAMPLE_BITS-1] ? (~x_avg + SAMPLE_BITS'(1)) : x_avg;

    // Gain product on the magnitude: negative values round up in magnitude,
    // which is the floor of the signed value, then clamp to one.
    assign gain_q     = mul_product[GAIN_FRAC +: (SAMPLE_BITS + 1)];
    assign gain_q_adj = gain_q
                      + (SAMPLE_BITS + 1)'(neg_reg && (|mul_product[GAIN_FRAC-1:0]));
    assign mag_clamp  = (gain_q_adj > ONE_Q) ? ONE_Q[SAMPLE_BITS-1:0]
                                             : gain_q_adj[SAMPLE_BITS-1:0];

    assign pw          = mul_product[FRAC_BITS +: SAMPLE_BITS];
    assign mag_diff    = mag_reg - div_quot[SAMPLE_BITS-1:0];
    assign scaled_diff = DIV_W'(mag_diff) * DIV_W'(p_plus);

    always_comb
    begin
        if (neg_reg)
        begin
            s_sat = (div_quot > DIV_W'(ONE_Q)) ? MIN_NEG
                                               : (~div_quot[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1));
        end
        else
        begin
            s_sat = (div_quot > DIV_W'(MAX_POS)) ? MAX_POS : div_quot[SAMPLE_BITS-1:0];
        end
    end

    assign sum_out   = {sat_reg[SAMPLE_BITS-1], sat_reg}
                     + {prior_shaped_reg[SAMPLE_BITS-1], prior_shaped_reg};
    assign out_value = high_rate_mode_reg ? sum_out[SAMPLE_BITS:1] : sat_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pow_cnt_next = pow_cnt_reg;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_numer    = '0;
        div_denom    = '0;
        mag_load     = 1'b0;
        sat_load     = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(gain_reg);
                    mul_b      = MUL_B_W'(x_mag);
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                if (mul_status.done)
                begin
                    mag_load     = 1'b1;
                    mul_start    = 1'b1;
                    mul_a        = MUL_A_W'(mag_clamp);
                    mul_b        = MUL_B_W'(mag_clamp);
                    pow_cnt_next = P_W'(1);
                    state_next   = ST_POW;
                end
            end
            ST_POW:
            begin
                if (mul_status.done)
                begin
                    if (pow_cnt_reg == p_reg)
                    begin
                        div_start  = 1'b1;
                        div_numer  = DIV_W'(pw);
                        div_denom  = p_plus;
                        state_next = ST_DIV_T;
                    end
                    else
                    begin
                        mul_start    = 1'b1;
                        mul_a        = MUL_A_W'(pw);
                        mul_b        = MUL_B_W'(mag_reg);
                        pow_cnt_next = pow_cnt_reg + P_W'(1);
                    end
                end
            end
            ST_DIV_T:
            begin
                if (div_status.done)
                begin
                    div_start  = 1'b1;
                    div_numer  = scaled_diff;
                    div_denom  = p_reg;
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                if (div_status.done)
                begin
                    sat_load   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            pow_cnt_reg      <= '0;
            prior_input_reg  <= '0;
            prior_shaped_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pow_cnt_reg   <= pow_cnt_next;
            if (in_xfer && high_rate_mode_reg)
            begin
                prior_input_reg <= in_sample;
            end
            if (out_load && high_rate_mode_reg)
            begin
                prior_shaped_reg <= sat_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            neg_reg   <= x_avg[SAMPLE_BITS-1];
            frame_reg <= frame_last;
        end
        if (mag_load)
        begin
            mag_reg <= mag_clamp;
        end
        if (sat_load)
        begin
            sat_reg <= s_sat;
        end
        if (out_load)
        begin
            out_sample_reg     <= $signed(out_value);
            out_frame_last_reg <= frame_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_sample     = out_sample_reg;
    assign out_frame_last = out_frame_last_reg;

endmodule
